@@ rtl/core/tahc_pkg.sv @@
`default_nettype none

package tahc_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_MODE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIP_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_SECONDS     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REARM_SECONDS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IS_CRITICAL      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUIET_ENABLE     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUIET_START_HOUR = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUIET_END_HOUR   = 3'd7;

   typedef enum logic [1:0] {
      CMP_GREATER  = 2'd0,
      CMP_LESS     = 2'd1,
      CMP_AT_LEAST = 2'd2
   } compare_mode_type;

   typedef enum logic {
      EVENT_FIRING    = 1'b0,
      EVENT_RECOVERED = 1'b1
   } event_kind_type;

   typedef struct packed {
      logic [1:0]         compare_mode;
      logic signed [31:0] trip_threshold;
      logic [31:0]        hold_seconds;
      logic [31:0]        rearm_seconds;
      logic               is_critical;
      logic               quiet_enable;
      logic [4:0]         quiet_start_hour;
      logic [4:0]         quiet_end_hour;
   } cfg_type;

   // one classified tick, as queued between front and back
   typedef struct packed {
      logic               met;
      logic               notify;
      logic signed [31:0] value;
      logic [31:0]        now;
   } item_type;

endpackage

`default_nettype wire

@@ rtl/core/tahc_front.sv @@
`default_nettype none

module tahc_front
   import tahc_pkg::*;
(
   input  cfg_type            cfg,
   input  logic               sample_present,
   input  logic signed [31:0] sample_value,
   input  logic [31:0]        now_seconds,
   input  logic [4:0]         local_hour,
   output item_type           item
);

   logic cond;
   logic quiet;

   always_comb begin
      case (cfg.compare_mode)
         CMP_GREATER:  cond = sample_value >  cfg.trip_threshold;
         CMP_LESS:     cond = sample_value <  cfg.trip_threshold;
         CMP_AT_LEAST: cond = sample_value >= cfg.trip_threshold;
         default:      cond = 1'b0;
      endcase
   end

   // window may wrap midnight; equal hours means no window
   always_comb begin
      if (!cfg.quiet_enable || cfg.quiet_start_hour == cfg.quiet_end_hour) begin
         quiet = 1'b0;
      end else if (cfg.quiet_start_hour < cfg.quiet_end_hour) begin
         quiet = (local_hour >= cfg.quiet_start_hour) && (local_hour < cfg.quiet_end_hour);
      end else begin
         quiet = (local_hour >= cfg.quiet_start_hour) || (local_hour < cfg.quiet_end_hour);
      end
   end

   always_comb begin
      item.met    = sample_present && cond;
      item.notify = cfg.is_critical || !quiet;
      item.value  = sample_present ? sample_value : 32'sd0;
      item.now    = now_seconds;
   end

endmodule

`default_nettype wire

@@ rtl/core/tahc_queue.sv @@
`default_nettype none

module tahc_queue
   import tahc_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head_item
);

   localparam int unsigned PtrWidth = $clog2(Depth);
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   item_type              entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full      = count_ff == CntWidth'(Depth);
   assign not_empty = count_ff != '0;
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(Depth))
      else $error("queue count beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/core/tahc_back.sv @@
`default_nettype none

module tahc_back
   import tahc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_not_empty,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_event_kind,
   output logic               rsp_notify_flag,
   output logic signed [31:0] rsp_event_value,
   output logic [31:0]        rsp_event_time
);

   logic [31:0]        met_since_ff, met_since_in;
   logic [31:0]        last_fire_ff, last_fire_in;
   logic               announced_ff, announced_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff;
   logic               notify_ff;
   logic signed [31:0] value_ff;
   logic [31:0]        time_ff;

   logic [31:0] start_time;
   logic        hold_ok;
   logic        cool_ok;
   logic        emit;
   logic        emit_kind;

   // output register frees up this cycle if empty or being taken
   assign q_pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      start_time = (met_since_ff == '0) ? q_item.now : met_since_ff;
      hold_ok    = (q_item.now >= start_time) &&
                   ((q_item.now - start_time) >= cfg.hold_seconds);
      // zero last fire time means never fired
      cool_ok    = (last_fire_ff == '0) ||
                   ((q_item.now >= last_fire_ff) &&
                    ((q_item.now - last_fire_ff) >= cfg.rearm_seconds));
   end

   always_comb begin
      met_since_in = met_since_ff;
      last_fire_in = last_fire_ff;
      announced_in = announced_ff;
      emit         = 1'b0;
      emit_kind    = EVENT_FIRING;
      if (q_pop) begin
         if (q_item.met) begin
            met_since_in = start_time;
            if (hold_ok && !announced_ff && cool_ok) begin
               announced_in = 1'b1;
               last_fire_in = q_item.now;
               emit         = 1'b1;
            end
         end else begin
            met_since_in = '0;
            announced_in = 1'b0;
            if (announced_ff) begin
               emit      = 1'b1;
               emit_kind = EVENT_RECOVERED;
            end
         end
      end
      rsp_valid_in = q_pop ? emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         met_since_ff <= '0;
         last_fire_ff <= '0;
         announced_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         met_since_ff <= met_since_in;
         last_fire_ff <= last_fire_in;
         announced_ff <= announced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= emit_kind;
         notify_ff <= q_item.notify;
         value_ff  <= q_item.value;
         time_ff   <= q_item.now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_notify_flag = notify_ff;
   assign rsp_event_value = value_ff;
   assign rsp_event_time  = time_ff;

   a_fire_sets_announced: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_kind == EVENT_FIRING) |=> announced_ff && rsp_valid_ff)
      else $error("firing word without announced state");

   a_unmet_clears_start: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_item.met) |=> met_since_ff == '0 && !announced_ff)
      else $error("episode state not cleared on unmet tick");

   a_held_word_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !q_pop)
      else $error("queue popped over a stalled word");

endmodule

`default_nettype wire

@@ rtl/core/threshold_alarm_hold_cooldown.sv @@
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  sample_present, sample_value, now_seconds, local_hour
// rsp      out        rsp_valid / rsp_stall  event_kind, notify_flag, event_value, event_time
// csr      in         csr_write_enable       csr_index, csr_wdata (write only)
//
// one word per cycle sustained while no word is held by rsp_stall; an accepted word is classified into
// the queue, and its result is then registered in the output register by one state update in the back end.
// the back end's episode update (hold and cooldown subtract-compare) sets the rate.
// reset is synchronous and clears the queue, the episode state and all config registers to zero.
// req_stall rises only when the queue is full, which happens only while rsp_stall holds a word.

`default_nettype none

module threshold_alarm_hold_cooldown
   import tahc_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_sample_present,
   input  logic signed [31:0]         req_sample_value,
   input  logic [31:0]                req_now_seconds,
   input  logic [4:0]                 req_local_hour,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_kind,
   output logic                       rsp_notify_flag,
   output logic signed [31:0]         rsp_event_value,
   output logic [31:0]                rsp_event_time,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     push;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_COMPARE_MODE:     cfg_in.compare_mode     = csr_wdata[1:0];
            CSR_TRIP_THRESHOLD:   cfg_in.trip_threshold   = $signed(csr_wdata[31:0]);
            CSR_HOLD_SECONDS:     cfg_in.hold_seconds     = csr_wdata[31:0];
            CSR_REARM_SECONDS:    cfg_in.rearm_seconds    = csr_wdata[31:0];
            CSR_IS_CRITICAL:      cfg_in.is_critical      = csr_wdata[0];
            CSR_QUIET_ENABLE:     cfg_in.quiet_enable     = csr_wdata[0];
            CSR_QUIET_START_HOUR: cfg_in.quiet_start_hour = csr_wdata[4:0];
            CSR_QUIET_END_HOUR:   cfg_in.quiet_end_hour   = csr_wdata[4:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   tahc_front u_front (
      .cfg            (cfg_ff),
      .sample_present (req_sample_present),
      .sample_value   (req_sample_value),
      .now_seconds    (req_now_seconds),
      .local_hour     (req_local_hour),
      .item           (front_item)
   );

   tahc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   tahc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_not_empty     (q_not_empty),
      .q_item          (head_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_notify_flag (rsp_notify_flag),
      .rsp_event_value (rsp_event_value),
      .rsp_event_time  (rsp_event_time)
   );

endmodule

`default_nettype wire
